@@ rtl/core/pus_pkg.sv @@
// Shared types, widths and constant tables for the particle update pipeline.
// No dependencies; imported by the interfaces, pus_axis and particle_update_step.
`default_nettype none
package pus_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned FT_W    = 17;
  localparam int unsigned NOW_W   = 39;
  localparam int unsigned DIE_W   = 40;
  localparam int unsigned RAMP_W  = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned GRAV_W  = 15;
  localparam int unsigned PROD_W  = POS_W + FT_W + 1;
  localparam int unsigned ACC_W   = 36;
  localparam int unsigned RSUM_W  = 18;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = NOW_W;

  localparam logic [FT_W-1:0]  FRAME_TIME_RST = 17'd1092;
  localparam logic [NOW_W-1:0] NOW_TIME_RST   = '0;

  localparam logic [RSUM_W-1:0] FIRE_RAMP_END = 18'd24576;
  localparam logic [RSUM_W-1:0] EXPL_RAMP_END = 18'd32768;
  localparam logic [RAMP_W-1:0] FIRE_ALPHA_SPAN = 16'd24576;
  localparam logic [9:0]        DIV3_RECIP = 10'd683;
  localparam logic [7:0]        ALPHA_FULL = 8'hff;

  localparam logic [3:0] FIRE_RATE  = 4'd5;
  localparam logic [3:0] EXPL_RATE  = 4'd10;
  localparam logic [3:0] EXPL2_RATE = 4'd15;

  typedef enum logic [2:0] {
    KIND_STATIC,
    KIND_GRAV,
    KIND_SLOWGRAV,
    KIND_FIRE,
    KIND_EXPLODE,
    KIND_EXPLODE2,
    KIND_BLOB,
    KIND_BLOB2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TIME,
    CFG_NOW_TIME
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VOP_KEEP,
    VOP_GROW,
    VOP_DAMP1,
    VOP_DAMP4
  } vel_op_e;

  typedef enum logic [1:0] {
    GOP_NONE,
    GOP_ADD,
    GOP_SUB
  } grav_op_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pus_adv_t;

  localparam logic [COLOR_W-1:0] FIRE_TAB [8] = '{
    8'h6d, 8'h6b, 8'h06, 8'h05, 8'h04, 8'h03, 8'h00, 8'h00
  };
  localparam logic [COLOR_W-1:0] EXPL_TAB [8] = '{
    8'h6f, 8'h6d, 8'h6b, 8'h69, 8'h67, 8'h65, 8'h63, 8'h61
  };
  localparam logic [COLOR_W-1:0] EXPL2_TAB [8] = '{
    8'h6f, 8'h6e, 8'h6d, 8'h6c, 8'h6b, 8'h6a, 8'h68, 8'h66
  };

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic hi_same;
    hi_same = (v[ACC_W-1:POS_W-1] == '0) || (v[ACC_W-1:POS_W-1] == '1);
    if (hi_same) begin
      sat32 = v[POS_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat32 = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/pus_if.sv @@
// Valid/ready channel interfaces for particle words, result words and config writes.
// Depends on pus_pkg.
`default_nettype none
interface pus_in_if import pus_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                kind;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic signed [POS_W-1:0]   pos_z;
  logic signed [POS_W-1:0]   vel_x;
  logic signed [POS_W-1:0]   vel_y;
  logic signed [POS_W-1:0]   vel_z;
  logic [RAMP_W-1:0]         ramp_in;
  logic signed [DIE_W-1:0]   die_in;
  logic [COLOR_W-1:0]        color_in;

  modport source (output valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  ramp_in, die_in, color_in, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  ramp_in, die_in, color_in, output ready);
endinterface

interface pus_out_if import pus_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      expired;
  logic signed [POS_W-1:0]   new_pos_x;
  logic signed [POS_W-1:0]   new_pos_y;
  logic signed [POS_W-1:0]   new_pos_z;
  logic signed [POS_W-1:0]   new_vel_x;
  logic signed [POS_W-1:0]   new_vel_y;
  logic signed [POS_W-1:0]   new_vel_z;
  logic [RAMP_W-1:0]         ramp_out;
  logic [COLOR_W-1:0]        color_out;
  logic signed [DIE_W-1:0]   die_out;
  logic [COLOR_W-1:0]        alpha;

  modport source (output valid, expired, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                  new_vel_y, new_vel_z, ramp_out, color_out, die_out, alpha,
                  input ready);
  modport sink   (input valid, expired, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                  new_vel_y, new_vel_z, ramp_out, color_out, die_out, alpha,
                  output ready);
endinterface

interface pus_cfg_if import pus_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pus_axis.sv @@
// Three-stage datapath for one axis: velocity times frame time, position step,
// velocity grow/damp, then gravity. Depends on pus_pkg; stage enables from the top.
`default_nettype none
module pus_axis import pus_pkg::*; (
  input  wire                       clk_i,
  input  wire pus_adv_t             adv_i,
  input  wire signed [POS_W-1:0]    pos_i,
  input  wire signed [POS_W-1:0]    vel_i,
  input  wire [FT_W-1:0]            frame_time_i,
  input  wire [GRAV_W-1:0]          grav_i,
  input  wire                       keep_pos_i,
  input  wire vel_op_e              vel_op_i,
  input  wire grav_op_e             grav_op_i,
  output logic signed [POS_W-1:0]   pos_o,
  output logic signed [POS_W-1:0]   vel_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [POS_W-1:0]  pos1_q, vel1_q;
  logic [GRAV_W-1:0]        grav1_q, grav2_q;
  logic                     keep1_q;
  vel_op_e                  vop1_q;
  grav_op_e                 gop1_q, gop2_q;

  logic signed [ACC_W-1:0]  step1, step4, pos_ext, vel_ext, pos_sum, vel_sum;
  logic signed [POS_W-1:0]  pos2_d, pos2_q, vel2_d, vel2_q;
  logic signed [ACC_W-1:0]  vel2_ext, grav_ext, vel3_sum;
  logic signed [POS_W-1:0]  vel3_d;

  assign prod_d = vel_i * $signed({1'b0, frame_time_i});

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      prod_q  <= prod_d;
      pos1_q  <= pos_i;
      vel1_q  <= vel_i;
      grav1_q <= grav_i;
      keep1_q <= keep_pos_i;
      vop1_q  <= vel_op_i;
      gop1_q  <= grav_op_i;
    end
  end

  always_comb begin
    step1   = ACC_W'(prod_q >>> 16);
    step4   = ACC_W'(prod_q >>> 14);
    pos_ext = ACC_W'(pos1_q);
    vel_ext = ACC_W'(vel1_q);
    pos_sum = pos_ext + step1;
    pos2_d  = keep1_q ? pos1_q : sat32(pos_sum);
    case (vop1_q)
      VOP_GROW:  vel_sum = vel_ext + step4;
      VOP_DAMP1: vel_sum = vel_ext - step1;
      VOP_DAMP4: vel_sum = vel_ext - step4;
      default:   vel_sum = vel_ext;
    endcase
    vel2_d = sat32(vel_sum);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      pos2_q  <= pos2_d;
      vel2_q  <= vel2_d;
      grav2_q <= grav1_q;
      gop2_q  <= gop1_q;
    end
  end

  always_comb begin
    vel2_ext = ACC_W'(vel2_q);
    grav_ext = ACC_W'($signed({1'b0, grav2_q}));
    case (gop2_q)
      GOP_ADD: vel3_sum = vel2_ext + grav_ext;
      GOP_SUB: vel3_sum = vel2_ext - grav_ext;
      default: vel3_sum = vel2_ext;
    endcase
    vel3_d = sat32(vel3_sum);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      pos_o <= pos2_q;
      vel_o <= vel3_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/particle_update_step.sv @@
// Particle update step: an accepted word passes stages 1, 2 and 3 to the result word;
// throughput one word per cycle unless stalled; each stage holds its word while the next is full.
// Stage 1 holds the multipliers, stage 2 the position/velocity adds and ramp tables,
// stage 3 the gravity add and the output register.
// Reset clears stage valid bits and loads frame_time 1092 and now_time 0.
// Depends on pus_pkg, pus_if and pus_axis.
`default_nettype none
module particle_update_step import pus_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  pus_cfg_if.sink    cfg_i,
  pus_in_if.sink     in_i,
  pus_out_if.source  out_o
);

  logic [FT_W-1:0]  frame_time_q;
  logic [NOW_W-1:0] now_time_q;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  pus_adv_t adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_time_q <= FRAME_TIME_RST;
      now_time_q   <= NOW_TIME_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FRAME_TIME: frame_time_q <= cfg_i.data[FT_W-1:0];
        CFG_NOW_TIME:   now_time_q   <= cfg_i.data;
        default:        ;
      endcase
    end
  end

  assign rdy3 = !v3_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;
  assign adv = '{s1: rdy1, s2: rdy2, s3: rdy3};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 0: decode and narrow arithmetic
  logic                  exp0;
  logic [22:0]           ft_x40;
  logic [GRAV_W-1:0]     grav0;
  logic [3:0]            rate0;
  logic [20:0]           ft_rate;
  logic [RSUM_W-1:0]     rsum0;
  logic                  over0;
  logic [14:0]           adiff0;
  logic [22:0]           anum0;
  vel_op_e               vop_xy, vop_z;
  grav_op_e              gop_z;

  always_comb begin
    exp0    = in_i.die_in < $signed({1'b0, now_time_q});
    ft_x40  = {1'b0, frame_time_q, 5'b0} + {3'b0, frame_time_q, 3'b0};
    grav0   = ft_x40[22:8];
    case (in_i.kind)
      KIND_FIRE:     rate0 = FIRE_RATE;
      KIND_EXPLODE:  rate0 = EXPL_RATE;
      KIND_EXPLODE2: rate0 = EXPL2_RATE;
      default:       rate0 = '0;
    endcase
    ft_rate = 21'(frame_time_q) * 21'(rate0);
    rsum0   = RSUM_W'(in_i.ramp_in) + RSUM_W'(ft_rate[20:4]);
    over0   = in_i.ramp_in > FIRE_ALPHA_SPAN;
    adiff0  = 15'(FIRE_ALPHA_SPAN - in_i.ramp_in);
    anum0   = {adiff0, 8'b0} - 23'(adiff0);

    case (in_i.kind)
      KIND_EXPLODE, KIND_BLOB: vop_xy = VOP_GROW;
      KIND_EXPLODE2:           vop_xy = VOP_DAMP1;
      KIND_BLOB2:              vop_xy = VOP_DAMP4;
      default:                 vop_xy = VOP_KEEP;
    endcase
    vop_z = (in_i.kind == KIND_BLOB2) ? VOP_KEEP : vop_xy;
    case (in_i.kind)
      KIND_STATIC: gop_z = GOP_NONE;
      KIND_FIRE:   gop_z = GOP_ADD;
      default:     gop_z = GOP_SUB;
    endcase
    if (exp0) begin
      vop_xy = VOP_KEEP;
      vop_z  = VOP_KEEP;
      gop_z  = GOP_NONE;
    end
  end

  // stage 1
  logic                    exp1_q, over1_q;
  logic [2:0]              kind1_q;
  logic [RSUM_W-1:0]       rsum1_q;
  logic [RAMP_W-1:0]       ramp1_q;
  logic [COLOR_W-1:0]      color1_q;
  logic signed [DIE_W-1:0] die1_q;
  logic [9:0]              ay1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      exp1_q   <= exp0;
      over1_q  <= over0;
      kind1_q  <= in_i.kind;
      rsum1_q  <= rsum0;
      ramp1_q  <= in_i.ramp_in;
      color1_q <= in_i.color_in;
      die1_q   <= in_i.die_in;
      ay1_q    <= anum0[22:13];
    end
  end

  logic                    has_ramp, dead;
  logic [COLOR_W-1:0]      tab_col;
  logic [19:0]             aq;
  logic [RAMP_W-1:0]       ramp2_d;
  logic [COLOR_W-1:0]      color2_d, alpha2_d;
  logic signed [DIE_W-1:0] die2_d;

  always_comb begin
    has_ramp = 1'b1;
    case (kind1_q)
      KIND_FIRE: begin
        dead    = rsum1_q >= FIRE_RAMP_END;
        tab_col = FIRE_TAB[rsum1_q[14:12]];
      end
      KIND_EXPLODE: begin
        dead    = rsum1_q >= EXPL_RAMP_END;
        tab_col = EXPL_TAB[rsum1_q[14:12]];
      end
      KIND_EXPLODE2: begin
        dead    = rsum1_q >= EXPL_RAMP_END;
        tab_col = EXPL2_TAB[rsum1_q[14:12]];
      end
      default: begin
        has_ramp = 1'b0;
        dead     = 1'b0;
        tab_col  = color1_q;
      end
    endcase
    aq = 20'(ay1_q) * 20'(DIV3_RECIP);
    if (exp1_q || !has_ramp) begin
      ramp2_d  = ramp1_q;
      color2_d = color1_q;
      die2_d   = die1_q;
    end else begin
      ramp2_d  = (rsum1_q[RSUM_W-1:RAMP_W] != '0) ? '1 : rsum1_q[RAMP_W-1:0];
      color2_d = dead ? color1_q : tab_col;
      die2_d   = dead ? '1 : die1_q;
    end
    if (exp1_q) begin
      alpha2_d = '0;
    end else if (kind1_q == KIND_FIRE) begin
      alpha2_d = over1_q ? '0 : aq[18:11];
    end else begin
      alpha2_d = ALPHA_FULL;
    end
  end

  // stage 2
  logic                    exp2_q;
  logic [2:0]              kind2_q;
  logic [RAMP_W-1:0]       ramp2_q;
  logic [COLOR_W-1:0]      color2_q, alpha2_q;
  logic signed [DIE_W-1:0] die2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      exp2_q   <= exp1_q;
      kind2_q  <= kind1_q;
      ramp2_q  <= ramp2_d;
      color2_q <= color2_d;
      alpha2_q <= alpha2_d;
      die2_q   <= die2_d;
    end
  end

  // stage 3: output register
  logic                    exp3_q;
  logic [2:0]              kind3_q;
  logic [RAMP_W-1:0]       ramp3_q;
  logic [COLOR_W-1:0]      color3_q, alpha3_q;
  logic signed [DIE_W-1:0] die3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      exp3_q   <= exp2_q;
      kind3_q  <= kind2_q;
      ramp3_q  <= ramp2_q;
      color3_q <= color2_q;
      alpha3_q <= alpha2_q;
      die3_q   <= die2_q;
    end
  end

  pus_axis u_axis_x (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .pos_i        (in_i.pos_x),
    .vel_i        (in_i.vel_x),
    .frame_time_i (frame_time_q),
    .grav_i       (grav0),
    .keep_pos_i   (exp0),
    .vel_op_i     (vop_xy),
    .grav_op_i    (GOP_NONE),
    .pos_o        (out_o.new_pos_x),
    .vel_o        (out_o.new_vel_x)
  );

  pus_axis u_axis_y (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .pos_i        (in_i.pos_y),
    .vel_i        (in_i.vel_y),
    .frame_time_i (frame_time_q),
    .grav_i       (grav0),
    .keep_pos_i   (exp0),
    .vel_op_i     (vop_xy),
    .grav_op_i    (GOP_NONE),
    .pos_o        (out_o.new_pos_y),
    .vel_o        (out_o.new_vel_y)
  );

  pus_axis u_axis_z (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .pos_i        (in_i.pos_z),
    .vel_i        (in_i.vel_z),
    .frame_time_i (frame_time_q),
    .grav_i       (grav0),
    .keep_pos_i   (exp0),
    .vel_op_i     (vop_z),
    .grav_op_i    (gop_z),
    .pos_o        (out_o.new_pos_z),
    .vel_o        (out_o.new_vel_z)
  );

  assign out_o.valid     = v3_q;
  assign out_o.expired   = exp3_q;
  assign out_o.ramp_out  = ramp3_q;
  assign out_o.color_out = color3_q;
  assign out_o.die_out   = die3_q;
  assign out_o.alpha     = alpha3_q;

`ifndef SYNTHESIS
  a_expired_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && exp3_q |-> alpha3_q == '0)
    else $error("expired word with nonzero alpha");

  a_plain_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !exp3_q && kind3_q != KIND_FIRE |-> alpha3_q == ALPHA_FULL)
    else $error("non-fire word without full alpha");

  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy2 |=> v1_q)
    else $error("stage 1 word dropped while stalled");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v3_q |-> in_i.ready)
    else $error("input stalled with empty output stage");
`endif

endmodule
`default_nettype wire
